FILE: design/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg
// Types, constants and helpers for the bit vector store with popcount.
// ----------------------------------------------------------------------------
package bvp_pkg;

	localparam int MAX_BITS  = 4096;
	localparam int WORD_BITS = 64;
	localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW   = $clog2(NUM_WORDS);
	localparam int BIT_AW    = $clog2(WORD_BITS);
	localparam int LEN_W     = 13;
	localparam int IDX_W     = 16;
	localparam int ACT_W     = 3;
	localparam int CNT_W     = 32;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BITS);
	localparam logic             REG_LENGTH = 1'b0;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET_BIT  = 3'd0,
		ACT_CLR_BIT  = 3'd1,
		ACT_GET_BIT  = 3'd2,
		ACT_SET_WORD = 3'd3,
		ACT_CLR_WORD = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COUNT,
		ST_DONE
	} state_t;

	typedef logic [WORD_BITS-1:0] word_t;

	function automatic logic [2:0] pop4(input logic [3:0] v);
		pop4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
	endfunction

	function automatic logic [4:0] pop16(input logic [15:0] v);
		pop16 = 5'(pop4(v[3:0])) + 5'(pop4(v[7:4]))
			+ 5'(pop4(v[11:8])) + 5'(pop4(v[15:12]));
	endfunction

endpackage

FILE: design/bit_vector_store_with_popcount.sv
// ----------------------------------------------------------------------------
// bit_vector_store_with_popcount
// Bit store of 64-bit words with a write counter and a running ones count.
// ----------------------------------------------------------------------------
// Each item takes four steps from start to the done strobe: one to read the
// word from the single-port store, one to build the new word and write it
// back, one for 16-bit popcount partial sums and one to update the counters.
// busy is high from an accepted start until the done strobe, so a new item is
// taken in the cycle the done strobe shows the previous result. Results are
// shown for one cycle and cannot be stalled. Writing length_bits (saturated to
// 4096) clears the store, the write count and the ones count at once through
// per-word valid bits.
module bit_vector_store_with_popcount (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bvp_pkg::ACT_W-1:0]    action,
	input  logic [bvp_pkg::IDX_W-1:0]    bit_index,
	output logic                         done,
	output logic                         ok,
	output logic                         bit_value,
	output logic [bvp_pkg::CNT_W-1:0]    write_count,
	output logic [bvp_pkg::LEN_W-1:0]    ones_count,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bvp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bvp_pkg::DATA_W-1:0]   pwdata,
	output logic [bvp_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import bvp_pkg::*;

	state_t                 state_q, state_d;
	logic [LEN_W-1:0]       length_q;
	logic [CNT_W-1:0]       writes_q;
	logic [LEN_W-1:0]       ones_q;
	logic [NUM_WORDS-1:0]   valid_q;

	logic [ACT_W-1:0]       act_q;
	logic [WORD_AW-1:0]     waddr_q;
	logic [BIT_AW-1:0]      bsel_q;
	logic                   ok_q;
	logic                   bit_q;
	logic                   ent_valid_q;
	logic                   done_q;

	word_t                  mem [NUM_WORDS];
	word_t                  rdata_q;
	word_t                  old_m_q, new_m_q;
	logic [4:0]             pop_old_q [4];
	logic [4:0]             pop_new_q [4];

	logic                   accept;
	logic                   cfg_wr;
	logic [LEN_W-1:0]       len_in;
	logic                   is_write;
	word_t                  old_w, new_w, mask_w;
	logic [LEN_W-1:0]       lo, rem;
	logic [6:0]             sum_old, sum_new;

	assign pready  = 1'b1;
	assign prdata  = DATA_W'(length_q);
	assign cfg_wr  = psel & penable & pwrite & pready & (paddr[2] == REG_LENGTH);
	assign len_in  = (pwdata[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : pwdata[LEN_W-1:0];

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start & ~busy;

	assign done        = done_q;
	assign ok          = ok_q;
	assign bit_value   = bit_q;
	assign write_count = writes_q;
	assign ones_count  = ones_q;

	assign is_write = ok_q & (act_q != ACT_GET_BIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_READ;
			ST_READ:  state_d = ST_COUNT;
			ST_COUNT: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// word store: read at accept, written back in the cycle after
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= mem[bit_index[BIT_AW+WORD_AW-1:BIT_AW]];
		end
		if (state_q == ST_READ && is_write) begin
			mem[waddr_q] <= new_w;
		end
	end

	// old word, new word and mask of bits below the length
	always_comb begin
		old_w = ent_valid_q ? rdata_q : '0;
		new_w = old_w;
		unique case (act_q)
			ACT_SET_BIT:  new_w = old_w | (word_t'(1) << bsel_q);
			ACT_CLR_BIT:  new_w = old_w & ~(word_t'(1) << bsel_q);
			ACT_SET_WORD: new_w = '1;
			ACT_CLR_WORD: new_w = '0;
			default:      new_w = old_w;
		endcase
		lo  = LEN_W'({waddr_q, {BIT_AW{1'b0}}});
		rem = length_q - lo;
		if (length_q <= lo) begin
			mask_w = '0;
		end else if (rem >= LEN_W'(WORD_BITS)) begin
			mask_w = '1;
		end else begin
			mask_w = ~({WORD_BITS{1'b1}} << rem[BIT_AW-1:0]);
		end
	end

	always_comb begin
		sum_old = 7'(pop_old_q[0]) + 7'(pop_old_q[1]) + 7'(pop_old_q[2]) + 7'(pop_old_q[3]);
		sum_new = 7'(pop_new_q[0]) + 7'(pop_new_q[1]) + 7'(pop_new_q[2]) + 7'(pop_new_q[3]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			waddr_q <= bit_index[BIT_AW+WORD_AW-1:BIT_AW];
			bsel_q  <= bit_index[BIT_AW-1:0];
		end
		if (state_q == ST_READ) begin
			old_m_q <= old_w & mask_w;
			new_m_q <= new_w & mask_w;
		end
		if (state_q == ST_COUNT) begin
			for (int i = 0; i < 4; i++) begin
				pop_old_q[i] <= pop16(old_m_q[16*i +: 16]);
				pop_new_q[i] <= pop16(new_m_q[16*i +: 16]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= LEN_MAX;
			writes_q    <= '0;
			ones_q      <= '0;
			valid_q     <= '0;
			ok_q        <= 1'b0;
			bit_q       <= 1'b0;
			ent_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
			if (cfg_wr) begin
				length_q <= len_in;
				writes_q <= '0;
				ones_q   <= '0;
				valid_q  <= '0;
			end else begin
				if (accept) begin
					ok_q <= ({{(IDX_W-LEN_W){1'b0}}, length_q} > bit_index)
						& (action <= ACT_CLR_WORD);
					ent_valid_q <= valid_q[bit_index[BIT_AW+WORD_AW-1:BIT_AW]];
					bit_q <= 1'b0;
				end
				if (state_q == ST_READ) begin
					if (ok_q && act_q == ACT_GET_BIT) begin
						bit_q <= old_w[bsel_q];
					end
					if (is_write) begin
						valid_q[waddr_q] <= 1'b1;
					end
				end
				if (state_q == ST_DONE && is_write) begin
					writes_q <= writes_q + 1'b1;
					ones_q   <= ones_q + LEN_W'(sum_new) - LEN_W'(sum_old);
				end
			end
		end
	end

endmodule

FILE: sim/bit_vector_store_with_popcount_tb.sv
// ----------------------------------------------------------------------------
// bit_vector_store_with_popcount_tb
// Self-checking bench for the bit store with write and ones counters: items
// go through a start/busy driver, results are checked against an in-bench
// model of the store, and the length register is changed over APB between
// phases.
// ----------------------------------------------------------------------------
module bit_vector_store_with_popcount_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bvp_pkg::*;

	localparam int WDOG_LIMIT = 5000;
	localparam int SETTLE_CYC = 8;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [IDX_W-1:0] idx;
	} request_t;

	typedef struct {
		logic             ok;
		logic             bit_value;
		logic [CNT_W-1:0] write_count;
		logic [LEN_W-1:0] ones_count;
	} status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [ACT_W-1:0]     action;
	logic [IDX_W-1:0]     bit_index;
	logic                 done;
	logic                 ok;
	logic                 bit_value;
	logic [CNT_W-1:0]     write_count;
	logic [LEN_W-1:0]     ones_count;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// model of the block
	word_t                store_words [NUM_WORDS];
	logic [CNT_W-1:0]     writes_done;
	logic [LEN_W-1:0]     ones_total;
	logic [LEN_W-1:0]     len_bits;

	request_t             request_q [$];
	status_t              expected_status_q [$];
	request_t             cur_req;
	int                   gap_left;
	bit                   no_gaps;
	int                   idle_cyc;
	int                   mismatches;
	int                   reg_errors;
	int                   n_accepted;
	int                   n_checked;
	int                   n_ok;
	int                   n_cfg;

	bit_vector_store_with_popcount dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.bit_index   (bit_index),
		.done        (done),
		.ok          (ok),
		.bit_value   (bit_value),
		.write_count (write_count),
		.ones_count  (ones_count),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic word_t word_valid_mask(int unsigned w);
		word_t       all1;
		int unsigned lo;
		all1 = '1;
		lo = w * WORD_BITS;
		if (lo >= len_bits) return '0;
		if (len_bits - lo >= WORD_BITS) return all1;
		return all1 >> (WORD_BITS - (len_bits - lo));
	endfunction

	function automatic void clear_store();
		foreach (store_words[i]) store_words[i] = '0;
		writes_done = '0;
		ones_total = '0;
	endfunction

	// one read-modify-write of the store, returns the status the block reports
	function automatic status_t apply_request(request_t rq);
		status_t     r;
		word_t       old_w;
		word_t       new_w;
		word_t       vmask;
		int unsigned w;
		int unsigned b;
		r.ok = 1'b0;
		r.bit_value = 1'b0;
		w = rq.idx / WORD_BITS;
		b = rq.idx % WORD_BITS;
		if (rq.idx < len_bits && rq.act <= ACT_CLR_WORD) begin
			old_w = store_words[w];
			new_w = old_w;
			vmask = word_valid_mask(w);
			r.ok = 1'b1;
			case (rq.act)
				ACT_SET_BIT:  new_w[b] = 1'b1;
				ACT_CLR_BIT:  new_w[b] = 1'b0;
				ACT_GET_BIT:  r.bit_value = old_w[b];
				ACT_SET_WORD: new_w = '1;
				default:      new_w = '0;
			endcase
			if (rq.act != ACT_GET_BIT) begin
				store_words[w] = new_w;
				ones_total = LEN_W'(int'(ones_total) + $countones(new_w & vmask)
					- $countones(old_w & vmask));
				writes_done = writes_done + 1'b1;
			end
		end
		r.write_count = writes_done;
		r.ones_count = ones_total;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// mostly in-range items so the store fills up, the rest is noise
	function automatic request_t gen_request(int len);
		request_t rq;
		int       r;
		int       s;
		int       span;
		r = $urandom_range(99);
		if (len == 0 || r < 12) begin
			rq.act = ACT_W'($urandom_range(7));
			if ($urandom_range(1))
				rq.idx = IDX_W'($urandom);
			else
				rq.idx = IDX_W'(len + $urandom_range(70));
		end else begin
			rq.act = ACT_W'($urandom_range(int'(ACT_CLR_WORD)));
			s = $urandom_range(9);
			if (s < 5) begin
				rq.idx = IDX_W'($urandom_range(len - 1));
			end else if (s < 8) begin
				span = (len - 1 < 127) ? len - 1 : 127;
				rq.idx = IDX_W'(len - 1 - $urandom_range(span));
			end else begin
				span = (len - 1 < 255) ? len - 1 : 255;
				rq.idx = IDX_W'($urandom_range(span));
			end
		end
		return rq;
	endfunction

	task automatic push_req(logic [ACT_W-1:0] act, int idx);
		request_t rq;
		rq.act = act;
		rq.idx = IDX_W'(idx);
		request_q.push_back(rq);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (request_q.size() != 0 || expected_status_q.size() != 0 || start);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write the length register, then read it back
	task automatic set_length(logic [DATA_W-1:0] value);
		int unsigned v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_LENGTH, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = value & 32'h1FFF;
		len_bits = (v > MAX_BITS) ? LEN_MAX : LEN_W'(v);
		clear_store();
		n_cfg++;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[LEN_W-1:0] !== len_bits) begin
			$error("length_bits: expected %0d, got %0d", len_bits, prdata[LEN_W-1:0]);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			request_q.push_back(gen_request(len_bits));
			// pause once in mid phase until every result is back
			if (i == n / 2) wait_drained();
		end
		wait_drained();
	endtask

	// driver
	always @(posedge clk) begin : driver
		request_t nxt;
		logic     taken;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				expected_status_q.push_back(apply_request(cur_req));
				n_accepted++;
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (request_q.size() > 0) begin
					nxt = request_q.pop_front();
					cur_req <= nxt;
					action <= nxt.act;
					bit_index <= nxt.idx;
					start <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		status_t e;
		if (arst_n && done) begin
			if (expected_status_q.size() == 0) begin
				$error("result with no item pending");
				mismatches++;
			end else begin
				e = expected_status_q.pop_front();
				n_checked++;
				if (e.ok) n_ok++;
				if (ok !== e.ok) begin
					$error("ok: expected %0d, got %0d", e.ok, ok);
					mismatches++;
				end
				if (bit_value !== e.bit_value) begin
					$error("bit_value: expected %0d, got %0d", e.bit_value, bit_value);
					mismatches++;
				end
				if (write_count !== e.write_count) begin
					$error("write_count: expected %0d, got %0d", e.write_count, write_count);
					mismatches++;
				end
				if (ones_count !== e.ones_count) begin
					$error("ones_count: expected %0d, got %0d", e.ones_count, ones_count);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready) || !arst_n)
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("bit_vector_store_with_popcount_tb: done, errors");
			$finish;
		end
	end

	initial begin
		int lens [8];
		arst_n = 1'b0;
		start = 1'b0;
		action = '0;
		bit_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_left = 0;
		no_gaps = 1'b0;
		idle_cyc = 0;
		mismatches = 0;
		reg_errors = 0;
		n_accepted = 0;
		n_checked = 0;
		n_ok = 0;
		n_cfg = 0;
		len_bits = LEN_MAX;
		clear_store();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents, both ends of the vector, word ops, bad index and action
		@(negedge clk);
		push_req(ACT_GET_BIT, 0);
		push_req(ACT_SET_BIT, 0);
		push_req(ACT_SET_BIT, 4095);
		push_req(ACT_GET_BIT, 4095);
		push_req(ACT_GET_BIT, 4094);
		push_req(ACT_SET_WORD, 130);
		push_req(ACT_CLR_BIT, 130);
		push_req(ACT_GET_BIT, 130);
		push_req(ACT_CLR_WORD, 191);
		push_req(ACT_SET_BIT, 65535);
		push_req(ACT_GET_BIT, 4096);
		push_req(ACT_W'(int'(ACT_CLR_WORD) + 1), 0);
		push_req(ACT_W'(int'(ACT_CLR_WORD) + 2), 1);
		push_req(ACT_W'(int'(ACT_CLR_WORD) + 3), 2);
		push_req(ACT_CLR_BIT, 0);
		wait_drained();

		// empty vector: everything fails
		set_length(32'd0);
		@(negedge clk);
		push_req(ACT_SET_BIT, 0);
		push_req(ACT_GET_BIT, 0);
		wait_drained();

		// length inside a word: set word must count only the valid bits
		set_length(32'd100);
		@(negedge clk);
		push_req(ACT_SET_WORD, 70);
		push_req(ACT_SET_BIT, 99);
		push_req(ACT_GET_BIT, 99);
		push_req(ACT_SET_BIT, 100);
		push_req(ACT_CLR_WORD, 64);
		wait_drained();

		// oversized value with junk above the field saturates, store is cleared
		set_length(32'hFFFF_1FFF);
		@(negedge clk);
		push_req(ACT_GET_BIT, 4095);
		wait_drained();

		lens = '{4096, 1, 64, 65, 4095, 200, 8191, $urandom_range(4096, 1)};
		foreach (lens[i]) begin
			set_length(DATA_W'(lens[i]));
			no_gaps = (i % 3 == 1);
			@(negedge clk);
			run_random(220);
		end
		set_length(32'd0);
		no_gaps = 1'b0;
		@(negedge clk);
		run_random(60);

		repeat (SETTLE_CYC) @(posedge clk);
		$display("covered %0d items (%0d ok, %0d checked) over %0d length settings",
			n_accepted, n_ok, n_checked, n_cfg);
		$display("lengths: 0, 1, 64, 65, 100, 200, 4095, 4096 and saturated values");
		if (mismatches == 0 && reg_errors == 0 && expected_status_q.size() == 0) begin
			$display("bit_vector_store_with_popcount_tb: done, clean");
		end else begin
			$display("bit_vector_store_with_popcount_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: bit_vector_store_with_popcount.f
design/bvp_pkg.sv
design/bit_vector_store_with_popcount.sv
sim/bit_vector_store_with_popcount_tb.sv
